@@ src/assert_macros.svh @@
// assertion macros shared by the rtl of the fixed width bit packer
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FWBP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("fwbp assertion failed");
// expression must never be true outside reset
`define FWBP_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("fwbp forbidden condition seen");
`else
`define FWBP_ASSERT(label, clk, rst_n, prop)
`define FWBP_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ src/fwbp_pkg.sv @@
// package of the fixed width bit packer: widths, constants and the result type
// used by fwbp_pack and fixed_width_bit_packer_unit
package fwbp_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int WIDTH_W   = 5;
	localparam int BYTE_W    = 8;
	localparam int PEND_W    = 7;
	localparam int PCNT_W    = 3;
	localparam int ACC_W     = PEND_W + SAMPLE_W;
	localparam int ALIGN_W   = 24;
	localparam int TOTAL_W   = 5;
	localparam int MAX_BYTES = 3;
	localparam int NCNT_W    = 2;

	localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 5'd16;
	localparam logic [WIDTH_W-1:0] RESET_WIDTH = 5'd12;

	typedef logic [BYTE_W-1:0] byte_t;

	// what one sample turns into
	typedef struct packed {
		byte_t [MAX_BYTES-1:0]  bytes;
		logic [MAX_BYTES-1:0]   last;
		logic [NCNT_W-1:0]      count;
		logic [PEND_W-1:0]      next_bits;
		logic [PCNT_W-1:0]      next_cnt;
	} pack_res_t;

endpackage

@@ src/fwbp_pack.sv @@
// combinational packing of one sample onto the pending bits
// depends on fwbp_pkg
module fwbp_pack (
	input  logic [fwbp_pkg::SAMPLE_W-1:0] sample,
	input  logic                          end_of_block,
	input  logic [fwbp_pkg::WIDTH_W-1:0]  bit_width,
	input  logic [fwbp_pkg::PEND_W-1:0]   pend_bits,
	input  logic [fwbp_pkg::PCNT_W-1:0]   pend_cnt,
	output fwbp_pkg::pack_res_t           res
);

	logic [fwbp_pkg::WIDTH_W-1:0]   w;
	logic [fwbp_pkg::SAMPLE_W-1:0]  mask;
	logic [fwbp_pkg::SAMPLE_W-1:0]  smask;
	logic [fwbp_pkg::ACC_W-1:0]     acc;
	logic [fwbp_pkg::TOTAL_W-1:0]   total;
	logic [fwbp_pkg::TOTAL_W-1:0]   shamt;
	logic [fwbp_pkg::ALIGN_W-1:0]   aligned;
	logic [fwbp_pkg::PCNT_W-1:0]    rem;
	logic [fwbp_pkg::PEND_W-1:0]    rem_mask;
	logic [fwbp_pkg::NCNT_W-1:0]    n;

	always_comb begin
		w     = (bit_width > fwbp_pkg::MAX_WIDTH) ? fwbp_pkg::MAX_WIDTH : bit_width;
		mask  = ~({fwbp_pkg::SAMPLE_W{1'b1}} << w);
		smask = sample & mask;
		acc   = (fwbp_pkg::ACC_W'(pend_bits) << w) | fwbp_pkg::ACC_W'(smask);
		total = fwbp_pkg::TOTAL_W'(pend_cnt) + w;
		// left align so the earliest bit lands in bit 23, padding zeros below
		shamt   = fwbp_pkg::TOTAL_W'(fwbp_pkg::ALIGN_W) - total;
		aligned = fwbp_pkg::ALIGN_W'({1'b0, acc} << shamt);
		rem      = total[fwbp_pkg::PCNT_W-1:0];
		rem_mask = (fwbp_pkg::PEND_W'(1) << rem) - fwbp_pkg::PEND_W'(1);
		n = total[fwbp_pkg::TOTAL_W-1:fwbp_pkg::PCNT_W]
			+ fwbp_pkg::NCNT_W'(end_of_block && (rem != '0));

		res.bytes[0] = aligned[23:16];
		res.bytes[1] = aligned[15:8];
		res.bytes[2] = aligned[7:0];
		for (int i = 0; i < fwbp_pkg::MAX_BYTES; i++) begin
			res.last[i] = end_of_block && (n == fwbp_pkg::NCNT_W'(i + 1));
		end
		res.count = n;
		if (end_of_block) begin
			res.next_bits = '0;
			res.next_cnt  = '0;
		end else begin
			res.next_bits = acc[fwbp_pkg::PEND_W-1:0] & rem_mask;
			res.next_cnt  = rem;
		end
	end

endmodule

@@ src/fixed_width_bit_packer_unit.sv @@
// top level of the fixed width bit packer: input register, packing logic, byte queue
// depends on fwbp_pkg, fwbp_pack and assert_macros.svh
//
// Packs the low bit_width bits (0..16, larger values act as 16) of each sample into
// a byte stream, earliest bit in bit 7, no gaps. A sample flagged end_of_block
// flushes any partial byte with zero padding and marks its final byte last_byte.
// A sample is registered, then packed combinationally into a three entry byte queue,
// which drains one byte per cycle while byte_stall is low. A held sample loads once
// the queue is empty or its last byte leaves; sample_stall holds the input till then,
// and the output byte per cycle sets the sample rate. An accepted sample passes the
// input register and then the byte queue before its first byte appears. bit_width
// is to be written by the user through cfg_valid/cfg_ready while no transaction is in
// flight; the block itself does not enforce it.
`include "assert_macros.svh"
module fixed_width_bit_packer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fwbp_pkg::WIDTH_W-1:0]  bit_width,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [fwbp_pkg::SAMPLE_W-1:0] sample,
	input  logic                          end_of_block,
	output logic                          byte_valid,
	input  logic                          byte_stall,
	output logic [fwbp_pkg::BYTE_W-1:0]   packed_byte,
	output logic                          last_byte
);

	logic [fwbp_pkg::WIDTH_W-1:0]   width_q;
	logic                           valid_s1;
	logic [fwbp_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                           eob_s1;
	logic [fwbp_pkg::PEND_W-1:0]    pend_bits_q;
	logic [fwbp_pkg::PCNT_W-1:0]    pend_cnt_q;
	fwbp_pkg::byte_t [fwbp_pkg::MAX_BYTES-1:0] buf_q;
	logic [fwbp_pkg::MAX_BYTES-1:0] last_q;
	logic [fwbp_pkg::NCNT_W-1:0]    cnt_q;
	fwbp_pkg::pack_res_t            res;
	logic                           pop;
	logic                           load;
	logic                           accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= fwbp_pkg::RESET_WIDTH;
		end else if (cfg_valid && cfg_ready) begin
			width_q <= bit_width;
		end
	end

	fwbp_pack u_pack (
		.sample       (sample_s1),
		.end_of_block (eob_s1),
		.bit_width    (width_q),
		.pend_bits    (pend_bits_q),
		.pend_cnt     (pend_cnt_q),
		.res          (res)
	);

	assign byte_valid  = (cnt_q != '0);
	assign packed_byte = buf_q[0];
	assign last_byte   = last_q[0];
	assign pop         = byte_valid && !byte_stall;
	// queue free once its last byte leaves this cycle
	assign load         = valid_s1 && ((cnt_q == '0) || ((cnt_q == 2'd1) && pop));
	assign sample_stall = valid_s1 && !load;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			eob_s1    <= end_of_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			cnt_q       <= '0;
			last_q      <= '0;
		end else if (load) begin
			pend_bits_q <= res.next_bits;
			pend_cnt_q  <= res.next_cnt;
			cnt_q       <= res.count;
			last_q      <= res.last;
		end else if (pop) begin
			cnt_q  <= cnt_q - 2'd1;
			last_q <= {1'b0, last_q[fwbp_pkg::MAX_BYTES-1:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res.bytes;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	// the last byte of a block is the final queued entry
	`FWBP_ASSERT(a_last_is_final, clk, arst_n, (byte_valid && last_byte) |-> (cnt_q == 2'd1))
	// a flushed block leaves nothing pending
	`FWBP_ASSERT(a_flush_clears, clk, arst_n, (load && eob_s1) |=> (pend_cnt_q == '0))
	// pending bits above the pending count stay zero
	`FWBP_NEVER(a_pend_clean, clk, arst_n, (pend_bits_q >> pend_cnt_q) != '0)
	// stall only when a sample is held in the input register
	`FWBP_NEVER(a_stall_held, clk, arst_n, sample_stall && !valid_s1)

endmodule
